[hdl/lkh_pkg.sv]
// Package for the layered key to HID report unit: sizes, field widths,
// opcodes and reset values of the layer value registers. No dependencies.
`timescale 1ns / 1ps

package lkh_pkg;

	localparam int KEY_COUNT    = 64;
	localparam int LAYER_COUNT  = 4;
	localparam int REPORT_SLOTS = 6;

	localparam int KEY_W    = 6;
	localparam int LAYER_W  = 2;
	localparam int BYTE_W   = 8;
	localparam int ENTRY_W  = 24;
	localparam int CFG_REGS = 4;
	localparam int CFG_AW   = 2;

	localparam int KEY_AW   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int LAYER_AW = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;

	// report slot numbers as kept in a release record
	localparam int FIRST_SLOT    = 2;
	localparam int RESERVED_SLOT = 1;

	localparam logic [ENTRY_W-1:0] ATTR_MASK = 24'hFFFF00;
	localparam logic [ENTRY_W-1:0] CODE_MASK = 24'h0000FF;
	localparam int MOD_SHIFT   = 8;
	localparam int LAYER_SHIFT = 16;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [ENTRY_W-1:0] entry_t;

	typedef enum logic [1:0] {
		OP_KEY   = 2'd0,
		OP_LOAD  = 2'd1,
		OP_FLUSH = 2'd2
	} opcode_t;

	localparam byte_t LAYER_VALUE_RESET [CFG_REGS] = '{8'd0, 8'd1, 8'd2, 8'd4};

endpackage

[hdl/lkh_ifs.sv]
// Stream interfaces of the layered key to HID report unit: the input word
// channel and the report channel. Depends on lkh_pkg.
`timescale 1ns / 1ps

interface lkh_sample_if import lkh_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          opcode;
	logic [KEY_W-1:0]    key_index;
	logic                pressed;
	logic [LAYER_W-1:0]  map_layer;
	logic [ENTRY_W-1:0]  map_entry;

	modport source (output valid, opcode, key_index, pressed, map_layer, map_entry,
		input ready);
	modport sink (input valid, opcode, key_index, pressed, map_layer, map_entry,
		output ready);
endinterface

interface lkh_report_if import lkh_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t report_modifiers;
	byte_t report_key_a;
	byte_t report_key_b;
	byte_t report_key_c;
	byte_t report_key_d;
	byte_t report_key_e;
	byte_t report_key_f;
	byte_t active_layer_bits;

	modport source (output valid, report_modifiers, report_key_a, report_key_b,
		report_key_c, report_key_d, report_key_e, report_key_f, active_layer_bits,
		input ready);
	modport sink (input valid, report_modifiers, report_key_a, report_key_b,
		report_key_c, report_key_d, report_key_e, report_key_f, active_layer_bits,
		output ready);
endinterface

[hdl/layered_key_to_hid_report_unit.sv]
// Layered key to HID report unit: keymap, per-key state and 6KRO report.
// Depends on lkh_pkg and the interfaces in lkh_ifs.sv.
//
//   channel   dir  contents
//   sample    in   opcode, key_index, pressed, map_layer, map_entry
//   report    out  modifier byte, six key slots, active layer bits
//   cfg_*     in   layer value register writes, no read-back
//
// One word per cycle while the report channel is not stalled: the keymap
// row, release record and held flag are read at acceptance into stage 1,
// and the report logic then runs from stage 1 into the result register.
// Keymap loads are written at acceptance; release records and held flags are
// written by the report stage and bypassed into the read of the following word.
// arst_n clears report, modifiers, layer bits, held flags and valids; the
// memories are not cleared. A stalled report holds one more word in stage 1.
`timescale 1ns / 1ps

module layered_key_to_hid_report_unit import lkh_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	lkh_sample_if.sink         sample,
	lkh_report_if.source       report,
	input  logic               cfg_we,
	input  logic [CFG_AW-1:0]  cfg_index,
	input  logic [BYTE_W-1:0]  cfg_data
);

	// memories: keymap rows hold all layers of one key
	entry_t [LAYER_COUNT-1:0] keymap_mem [KEY_COUNT];
	entry_t                   record_mem [KEY_COUNT];

	byte_t                    layer_value_q [CFG_REGS];
	logic [KEY_COUNT-1:0]     held_q;
	byte_t                    slots_q [REPORT_SLOTS];
	byte_t                    mods_q;
	byte_t                    layer_q;

	logic                     v_s1;
	logic [1:0]               op_s1;
	logic [KEY_W-1:0]         key_s1;
	logic                     pressed_s1;
	entry_t [LAYER_COUNT-1:0] row_s1;
	entry_t                   rec_rd_s1;
	logic                     byp_s1;
	entry_t                   byp_data_s1;
	logic                     held_s1;

	logic                     out_v_q;
	byte_t                    out_mods_q;
	byte_t                    out_keys_q [6];
	byte_t                    out_layer_q;

	logic                     accept;
	logic                     adv;
	logic                     fire;
	logic                     in_key_ok;
	logic                     in_layer_ok;

	byte_t                    nx_slots [REPORT_SLOTS];
	byte_t                    nx_mods;
	byte_t                    nx_layer;
	logic                     held_set;
	logic                     held_clr;
	logic                     rec_we;
	entry_t                   rec_wdata;
	logic [LAYER_AW-1:0]      lsel;
	entry_t                   entry;
	entry_t                   rec;
	byte_t                    code;
	logic                     found;
	byte_t                    slot_num;
	logic                     key_ok;
	logic                     is_held;

	assign adv          = !out_v_q || report.ready;
	assign fire         = v_s1 && adv;
	assign sample.ready = !v_s1 || adv;
	assign accept       = sample.valid && sample.ready;

	assign in_key_ok   = int'(sample.key_index) < KEY_COUNT;
	assign in_layer_ok = int'(sample.map_layer) < LAYER_COUNT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_REGS; i++) layer_value_q[i] <= LAYER_VALUE_RESET[i];
		end else if (cfg_we && int'(cfg_index) < CFG_REGS) begin
			layer_value_q[cfg_index] <= cfg_data;
		end
	end

	// keymap load at acceptance, row read for the word entering stage 1
	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1 <= keymap_mem[sample.key_index[KEY_AW-1:0]];
			if (sample.opcode == OP_LOAD && in_key_ok && in_layer_ok) begin
				keymap_mem[sample.key_index[KEY_AW-1:0]][sample.map_layer[LAYER_AW-1:0]]
					<= sample.map_entry;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_rd_s1 <= record_mem[sample.key_index[KEY_AW-1:0]];
		end
		if (rec_we) begin
			record_mem[key_s1[KEY_AW-1:0]] <= rec_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= sample.opcode;
			key_s1      <= sample.key_index;
			pressed_s1  <= sample.pressed;
			// record written this cycle is not yet in the memory read
			byp_s1      <= rec_we && (key_s1 == sample.key_index);
			byp_data_s1 <= rec_wdata;
			held_s1     <= (fire && (held_set || held_clr) && (key_s1 == sample.key_index)) ?
				held_set : held_q[sample.key_index[KEY_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	// report stage
	always_comb begin
		nx_slots  = slots_q;
		nx_mods   = mods_q;
		nx_layer  = layer_q;
		held_set  = 1'b0;
		held_clr  = 1'b0;
		rec_we    = 1'b0;
		rec_wdata = '0;
		found     = 1'b0;
		slot_num  = '0;

		// lowest matching register wins, layer 0 when none match
		lsel = '0;
		for (int i = LAYER_COUNT - 1; i >= 0; i--) begin
			if (layer_value_q[i] == layer_q) lsel = LAYER_AW'(i);
		end
		entry   = row_s1[lsel];
		code    = entry[BYTE_W-1:0];
		rec     = byp_s1 ? byp_data_s1 : rec_rd_s1;
		key_ok  = int'(key_s1) < KEY_COUNT;
		is_held = held_s1;

		case (op_s1)
			OP_KEY: begin
				if (key_ok && pressed_s1 && !is_held) begin
					if (code == '0) begin
						slot_num = BYTE_W'(RESERVED_SLOT);
						found    = 1'b1;
					end else begin
						for (int s = 0; s < REPORT_SLOTS; s++) begin
							if (!found && slots_q[s] == '0) begin
								nx_slots[s] = code;
								slot_num    = BYTE_W'(FIRST_SLOT + s);
								found       = 1'b1;
							end
						end
					end
					nx_mods  = mods_q | entry[MOD_SHIFT +: BYTE_W];
					nx_layer = layer_q | entry[LAYER_SHIFT +: BYTE_W];
					// full report: attributes still ORed in, key left unheld so a later press word is taken anew
					if (found) begin
						held_set  = 1'b1;
						rec_we    = fire;
						rec_wdata = (entry & ATTR_MASK) | (entry_t'(slot_num) & CODE_MASK);
					end
				end else if (key_ok && !pressed_s1 && is_held) begin
					for (int s = 0; s < REPORT_SLOTS; s++) begin
						if (rec[BYTE_W-1:0] == BYTE_W'(FIRST_SLOT + s)) nx_slots[s] = '0;
					end
					nx_mods  = mods_q ^ rec[MOD_SHIFT +: BYTE_W];
					nx_layer = layer_q ^ rec[LAYER_SHIFT +: BYTE_W];
					held_clr = 1'b1;
				end
			end
			OP_FLUSH: begin
				for (int s = 0; s < REPORT_SLOTS; s++) nx_slots[s] = '0;
				nx_mods = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			mods_q  <= '0;
			layer_q <= '0;
			for (int s = 0; s < REPORT_SLOTS; s++) slots_q[s] <= '0;
		end else if (fire) begin
			if (held_set) held_q[key_s1[KEY_AW-1:0]] <= 1'b1;
			if (held_clr) held_q[key_s1[KEY_AW-1:0]] <= 1'b0;
			mods_q  <= nx_mods;
			layer_q <= nx_layer;
			slots_q <= nx_slots;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (fire) begin
			out_v_q <= 1'b1;
		end else if (report.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_mods_q  <= nx_mods;
			out_layer_q <= nx_layer;
			for (int s = 0; s < 6; s++) begin
				out_keys_q[s] <= (s < REPORT_SLOTS) ? nx_slots[s] : '0;
			end
		end
	end

	assign report.valid             = out_v_q;
	assign report.report_modifiers  = out_mods_q;
	assign report.report_key_a      = out_keys_q[0];
	assign report.report_key_b      = out_keys_q[1];
	assign report.report_key_c      = out_keys_q[2];
	assign report.report_key_d      = out_keys_q[3];
	assign report.report_key_e      = out_keys_q[4];
	assign report.report_key_f      = out_keys_q[5];
	assign report.active_layer_bits = out_layer_q;

endmodule
